[sv/dafd_pkg.sv]
// ----------------------------------------------------------------------------
// dafd_pkg: shared definitions for the ADPCM frame decoder
// Queue entry and configuration types, register indexes, emit codes.
// ----------------------------------------------------------------------------
package dafd_pkg;

  localparam int FRAME_SAMPLES_DEF = 14;
  localparam int QUEUE_DEPTH       = 2;
  localparam int COEF_REGS         = 4;
  localparam int COEF_N            = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_ONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_TWO = 3'd5;

  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_ONE  = 2'd1;
  localparam logic [1:0] EMIT_TWO  = 2'd2;

  typedef struct packed {
    logic       reload;
    logic [3:0] nib_hi;
    logic [3:0] nib_lo;
    logic [1:0] emit;
    logic [3:0] gain;
    logic [2:0] pair;
  } qent_t;

  typedef struct packed {
    logic [COEF_REGS-1:0][CFG_DATA_W-1:0] coef;
    logic [15:0]                          hist_one;
    logic [15:0]                          hist_two;
  } cfg_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } qwr_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qrd_t;

endpackage

[sv/dsp_adpcm_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// dsp_adpcm_frame_decoder_top: 4-bit ADPCM frame decoder
// Byte stream of frames in, saturated 16-bit PCM samples out.
// ----------------------------------------------------------------------------
// The front end takes one byte per cycle unless the queue is full, and keeps
// frame position and header. Headers and data bytes with an emit count of
// zero take no engine time. A data byte becomes one or two samples, produced
// at one sample per cycle while the output is not stalled, by the predictor
// loop (history feeding both coefficient multipliers); a restart byte costs
// the engine a history reload. A two-entry queue sits between parser and
// engine. The registered output holds one sample; while it is stalled the
// engine stops, the queue fills and the input stalls in turn.
module dsp_adpcm_frame_decoder_top #(
  parameter int FRAME_SAMPLES = dafd_pkg::FRAME_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_stream_byte,
  input  logic [1:0]                          in_emit_count,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_sample,
  output logic                                out_last_of_item,
  input  logic                                cfg_we,
  input  logic [dafd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dafd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  dafd_pkg::cfg_t cfg_r;
  dafd_pkg::qwr_t q_wr;
  dafd_pkg::qrd_t q_rd;
  logic           q_full, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dafd_pkg::REG_COEF_A:   cfg_r.coef[0]  <= cfg_wdata;
        dafd_pkg::REG_COEF_B:   cfg_r.coef[1]  <= cfg_wdata;
        dafd_pkg::REG_COEF_C:   cfg_r.coef[2]  <= cfg_wdata;
        dafd_pkg::REG_COEF_D:   cfg_r.coef[3]  <= cfg_wdata;
        dafd_pkg::REG_HIST_ONE: cfg_r.hist_one <= cfg_wdata[15:0];
        dafd_pkg::REG_HIST_TWO: cfg_r.hist_two <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  dafd_front #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .in_emit_count  (in_emit_count),
    .in_restart     (in_restart),
    .q_full         (q_full),
    .q_wr           (q_wr)
  );

  dafd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  dafd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_rd             (q_rd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_last_of_item (out_last_of_item)
  );

endmodule

[sv/dafd_front.sv]
// ----------------------------------------------------------------------------
// dafd_front: stream parser
// Tracks frame position and header, classifies each byte, queues work.
// ----------------------------------------------------------------------------
module dafd_front #(
  parameter int FRAME_SAMPLES = dafd_pkg::FRAME_SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_stream_byte,
  input  logic [1:0]      in_emit_count,
  input  logic            in_restart,
  input  logic            q_full,
  output dafd_pkg::qwr_t  q_wr
);

  localparam int FRAME_BYTES = FRAME_SAMPLES / 2;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       header_r, header_nxt;
  logic             accept, is_header;
  logic [1:0]       emit_sat;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pos_cur  = in_restart ? '0 : pos_r;
  assign is_header = (pos_cur == '0) || (pos_cur > POS_W'(FRAME_BYTES));
  assign emit_sat = (in_emit_count > dafd_pkg::EMIT_TWO) ? dafd_pkg::EMIT_TWO : in_emit_count;

  always_comb begin
    pos_nxt    = pos_r;
    header_nxt = header_r;
    if (accept) begin
      if (is_header) begin
        header_nxt = in_stream_byte;
        pos_nxt    = POS_W'(1);
      end else if (pos_cur >= POS_W'(FRAME_BYTES)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_cur + 1'b1;
      end
    end
  end

  always_comb begin
    q_wr.push       = accept && (in_restart || (!is_header && emit_sat != dafd_pkg::EMIT_NONE));
    q_wr.ent.reload = in_restart;
    q_wr.ent.nib_hi = in_stream_byte[7:4];
    q_wr.ent.nib_lo = in_stream_byte[3:0];
    q_wr.ent.emit   = is_header ? dafd_pkg::EMIT_NONE : emit_sat;
    q_wr.ent.gain   = header_r[3:0];
    q_wr.ent.pair   = header_r[6:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      header_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      header_r <= header_nxt;
    end
  end

endmodule

[sv/dafd_queue.sv]
// ----------------------------------------------------------------------------
// dafd_queue: short work queue
// Decouples the stream parser from the sample engine.
// ----------------------------------------------------------------------------
module dafd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  dafd_pkg::qwr_t q_wr,
  output logic           q_full,
  input  logic           q_pop,
  output dafd_pkg::qrd_t q_rd
);

  localparam int DEPTH = dafd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dafd_pkg::qent_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_full    = (cnt_r == CNT_W'(DEPTH));
  assign do_push   = q_wr.push && !q_full;
  assign do_pop    = q_pop && (cnt_r != '0);
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.ent   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wr.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count over depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && q_full) |-> 1'b0)
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (cnt_r != '0))
    else $error("pop from empty queue");

endmodule

[sv/dafd_back.sv]
// ----------------------------------------------------------------------------
// dafd_back: sample engine
// Second-order predictor, one sample per cycle unless the output stalls, into a registered output.
// ----------------------------------------------------------------------------
module dafd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dafd_pkg::cfg_t      cfg,
  input  dafd_pkg::qrd_t      q_rd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_sample,
  output logic                out_last_of_item
);

  logic [dafd_pkg::COEF_N-1:0][15:0] coefs;
  logic signed [15:0] h1_r, h2_r, c0, c1, sat;
  logic signed [31:0] nsh, p0, p1, acc, shr;
  logic [31:0]        nv;
  logic [4:0]         sh_amt;
  logic [3:0]         nib;
  logic               sub_r, out_valid_r, slot_free, do_reload, do_sample, last;
  logic signed [15:0] out_sample_r;
  logic               out_last_r;

  assign coefs     = cfg.coef;
  assign slot_free = !out_valid_r || !out_stall;
  assign do_reload = q_rd.valid && q_rd.ent.reload;
  assign do_sample = q_rd.valid && !q_rd.ent.reload && slot_free;
  assign last      = sub_r || (q_rd.ent.emit == dafd_pkg::EMIT_ONE);
  assign q_pop     = do_reload || (do_sample && last);

  assign nib    = sub_r ? q_rd.ent.nib_lo : q_rd.ent.nib_hi;
  assign c0     = $signed(coefs[{q_rd.ent.pair, 1'b0}]);
  assign c1     = $signed(coefs[{q_rd.ent.pair, 1'b1}]);
  assign nv     = {{28{nib[3]}}, nib};
  assign sh_amt = 5'(q_rd.ent.gain) + 5'd11;
  assign nsh    = $signed(nv << sh_amt);
  assign p0     = h1_r * c0;
  assign p1     = h2_r * c1;
  assign acc    = nsh + p0 + p1 + 32'sd1024;
  assign shr    = acc >>> 11;

  always_comb begin
    if (shr > 32'sd32767) begin
      sat = 16'sh7FFF;
    end else if (shr < -32'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = shr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r        <= '0;
      h2_r        <= '0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_reload) begin
        h1_r <= cfg.hist_one;
        h2_r <= cfg.hist_two;
      end else if (do_sample) begin
        h1_r  <= sat;
        h2_r  <= h1_r;
        sub_r <= !last;
      end
      if (do_sample) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_sample) begin
      out_sample_r <= sat;
      out_last_r   <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_last_of_item = out_last_r;

  a_second_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    (do_sample && sub_r) |-> (q_rd.ent.emit == dafd_pkg::EMIT_TWO))
    else $error("second nibble on single-sample item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !do_sample)
    else $error("output overwritten while stalled");

endmodule

[test/dsp_adpcm_frame_decoder_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsp_adpcm_frame_decoder_checker: sample predictor and scoreboard
// Watches the register port and both item channels, tracks frame position,
// header and history, predicts every PCM sample and compares it in order.
// ----------------------------------------------------------------------------
module dsp_adpcm_frame_decoder_checker #(
  parameter int FRAME_SAMPLES = dafd_pkg::FRAME_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [7:0]                        in_stream_byte,
  input  logic [1:0]                        in_emit_count,
  input  logic                              in_restart,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [15:0]                out_sample,
  input  logic                              out_last_of_item,
  input  logic                              cfg_we,
  input  logic [dafd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dafd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                pcm_pending
);

  localparam int FRAME_BYTES = FRAME_SAMPLES / 2;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } pcm_t;

  logic [dafd_pkg::CFG_DATA_W-1:0] coef_reg [dafd_pkg::COEF_REGS];
  logic signed [15:0]    seed_one;
  logic signed [15:0]    seed_two;
  logic signed [15:0]    hist_one;
  logic signed [15:0]    hist_two;
  int unsigned           frame_pos;
  logic [7:0]            header;
  pcm_t                  pcm_q[$];
  int                    mismatches = 0;

  function automatic logic signed [15:0] coef_at(int unsigned k);
    return coef_reg[(k >> 2) & 3][(k & 3) * 16 +: 16];
  endfunction

  function automatic logic signed [15:0] adpcm_sample(logic [3:0] nib);
    logic [3:0]         gain;
    int unsigned        pair;
    logic signed [15:0] c0;
    logic signed [15:0] c1;
    logic signed [31:0] acc;
    logic signed [31:0] sh;
    gain = header[3:0];
    pair = header[6:4];
    c0   = coef_at(pair * 2);
    c1   = coef_at(pair * 2 + 1);
    acc  = {{28{nib[3]}}, nib};
    acc  = acc << (gain + 11);
    acc  = acc + hist_one * c0 + hist_two * c1 + 32'sd1024;
    sh   = acc >>> 11;
    if (sh > 32767) begin
      return 16'sh7FFF;
    end
    if (sh < -32768) begin
      return 16'sh8000;
    end
    return sh[15:0];
  endfunction

  task automatic take_byte(logic [7:0] b, logic [1:0] emit, logic rs);
    int         n;
    logic [3:0] nib;
    pcm_t       e;
    if (rs) begin
      hist_one  = seed_one;
      hist_two  = seed_two;
      frame_pos = 0;
    end
    if (frame_pos == 0 || frame_pos > FRAME_BYTES) begin
      header    = b;
      frame_pos = (FRAME_BYTES > 0) ? 1 : 0;
      return;
    end
    n = (emit > dafd_pkg::EMIT_TWO) ? 2 : emit;
    for (int i = 0; i < n; i++) begin
      nib      = (i == 0) ? b[7:4] : b[3:0];
      e.sample = adpcm_sample(nib);
      e.last   = (i + 1 == n);
      hist_two = hist_one;
      hist_one = e.sample;
      pcm_q.push_back(e);
    end
    if (frame_pos >= FRAME_BYTES) begin
      frame_pos = 0;
    end else begin
      frame_pos = (frame_pos + 1) & 15;
    end
  endtask

  task automatic report(string what, int got, int want);
    mismatches++;
    $display("[%0t] pcm mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_sample();
    pcm_t e;
    if (pcm_q.size() == 0) begin
      report("unexpected sample", out_sample, 0);
    end else begin
      e = pcm_q.pop_front();
      if (out_sample !== e.sample) begin
        report("sample", out_sample, e.sample);
      end
      if (out_last_of_item !== e.last) begin
        report("last_of_item", out_last_of_item, e.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < dafd_pkg::COEF_REGS; r++) begin
        coef_reg[r] = '0;
      end
      seed_one  = '0;
      seed_two  = '0;
      hist_one  = '0;
      hist_two  = '0;
      frame_pos = 0;
      header    = '0;
      pcm_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dafd_pkg::REG_COEF_A:   coef_reg[0] = cfg_wdata;
          dafd_pkg::REG_COEF_B:   coef_reg[1] = cfg_wdata;
          dafd_pkg::REG_COEF_C:   coef_reg[2] = cfg_wdata;
          dafd_pkg::REG_COEF_D:   coef_reg[3] = cfg_wdata;
          dafd_pkg::REG_HIST_ONE: seed_one    = cfg_wdata[15:0];
          dafd_pkg::REG_HIST_TWO: seed_two    = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_byte(in_stream_byte, in_emit_count, in_restart);
      end
      if (out_valid && !out_stall) begin
        check_sample();
      end
    end
    pcm_pending <= pcm_q.size();
    fail_count  <= mismatches;
  end

endmodule

[test/dsp_adpcm_frame_decoder_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsp_adpcm_frame_decoder_top_tb: testbench for the ADPCM frame decoder
// Directed frames, then phases of random bytes under varied coefficient and
// history settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module dsp_adpcm_frame_decoder_top_tb;

  localparam int FRAME_SAMPLES = dafd_pkg::FRAME_SAMPLES_DEF;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 73;
  localparam int DRAIN         = 16;

  // emit count above two, saturated by the block
  localparam logic [1:0] EMIT_OVER = 2'd3;

  localparam logic [dafd_pkg::CFG_IDX_W-1:0] COEF_IDX [dafd_pkg::COEF_REGS] =
    '{dafd_pkg::REG_COEF_A, dafd_pkg::REG_COEF_B,
      dafd_pkg::REG_COEF_C, dafd_pkg::REG_COEF_D};

  typedef enum int {COEF_MODERATE, COEF_FULL, COEF_EXTREME, COEF_ZERO} coef_mode_t;

  logic                            clk              = 1'b0;
  logic                            rst_n            = 1'b0;
  logic                            in_valid         = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_stream_byte   = '0;
  logic [1:0]                      in_emit_count    = dafd_pkg::EMIT_NONE;
  logic                            in_restart       = 1'b0;
  logic                            out_valid;
  logic                            out_stall        = 1'b0;
  logic signed [15:0]              out_sample;
  logic                            out_last_of_item;
  logic                            cfg_we           = 1'b0;
  logic [dafd_pkg::CFG_IDX_W-1:0]  cfg_index        = dafd_pkg::REG_COEF_A;
  logic [dafd_pkg::CFG_DATA_W-1:0] cfg_wdata        = '0;

  int fail_count;
  int pcm_pending;
  int idle_pct  = 0;
  int stall_left = 0;

  always #4 clk = ~clk;

  dsp_adpcm_frame_decoder_top #(.FRAME_SAMPLES(FRAME_SAMPLES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stream_byte(in_stream_byte), .in_emit_count(in_emit_count),
    .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample(out_sample), .out_last_of_item(out_last_of_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  dsp_adpcm_frame_decoder_checker #(.FRAME_SAMPLES(FRAME_SAMPLES)) pcm_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stream_byte(in_stream_byte), .in_emit_count(in_emit_count),
    .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample(out_sample), .out_last_of_item(out_last_of_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pcm_pending(pcm_pending)
  );

  // random receiver stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [dafd_pkg::CFG_DATA_W-1:0] coef_word(coef_mode_t mode);
    logic [dafd_pkg::CFG_DATA_W-1:0] w;
    logic [15:0]                     c;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      case (mode)
        COEF_MODERATE: c = 16'($urandom_range(0, 8191)) - 16'd4096;
        COEF_EXTREME:  c = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        COEF_ZERO:     c = '0;
        default:       c = 16'($urandom);
      endcase
      w[k*16 +: 16] = c;
    end
    return w;
  endfunction

  task automatic send_byte(logic [7:0] b, logic [1:0] emit, logic rs);
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    in_emit_count  <= emit;
    in_restart     <= rs;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_random_byte();
    logic [1:0] emit;
    int         pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       emit = dafd_pkg::EMIT_NONE;
      1:       emit = dafd_pkg::EMIT_ONE;
      2:       emit = EMIT_OVER;
      default: emit = dafd_pkg::EMIT_TWO;
    endcase
    send_byte(8'($urandom_range(0, 255)), emit, $urandom_range(0, 24) == 0);
  endtask

  // wait until every pending sample is out, plus engine slack
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pcm_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic program_regs(coef_mode_t mode, logic [15:0] h1, logic [15:0] h2);
    cfg_we <= 1'b1;
    for (int k = 0; k < dafd_pkg::COEF_REGS; k++) begin
      cfg_index <= COEF_IDX[k];
      cfg_wdata <= coef_word(mode);
      @(posedge clk);
    end
    cfg_index <= dafd_pkg::REG_HIST_ONE;
    cfg_wdata <= {{48{h1[15]}}, h1};
    @(posedge clk);
    cfg_index <= dafd_pkg::REG_HIST_TWO;
    cfg_wdata <= {{48{h2[15]}}, h2};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    coef_mode_t  modes [PHASES];
    int          idles [PHASES];
    logic [15:0] h1;
    logic [15:0] h2;
    int          waited;

    modes = '{COEF_MODERATE, COEF_EXTREME, COEF_FULL, COEF_MODERATE, COEF_ZERO,
              COEF_MODERATE};
    idles = '{25, 40, 0, 25, 40, 0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_regs(COEF_MODERATE, 16'($urandom), 16'($urandom));
    idle_pct = 20;
    send_byte(8'h0B, dafd_pkg::EMIT_NONE, 1'b1);
    send_byte(8'h7F, dafd_pkg::EMIT_TWO,  1'b0);
    send_byte(8'h80, dafd_pkg::EMIT_TWO,  1'b0);
    send_byte(8'h08, dafd_pkg::EMIT_ONE,  1'b0);
    send_byte(8'hF0, EMIT_OVER,           1'b0);
    send_byte(8'h00, dafd_pkg::EMIT_NONE, 1'b0);
    send_byte(8'hFF, dafd_pkg::EMIT_TWO,  1'b0);
    send_byte(8'h17, dafd_pkg::EMIT_TWO,  1'b0);
    // frame full: next byte is a header selecting the last coefficient pair
    send_byte(8'hFF, dafd_pkg::EMIT_TWO,  1'b0);
    send_byte(8'h7F, dafd_pkg::EMIT_TWO,  1'b0);
    send_byte(8'h88, dafd_pkg::EMIT_TWO,  1'b0);
    // restart in the middle of a frame
    send_byte(8'h9C, dafd_pkg::EMIT_TWO,  1'b1);
    send_byte(8'h5A, dafd_pkg::EMIT_TWO,  1'b0);
    send_byte(8'h00, dafd_pkg::EMIT_ONE,  1'b0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        1: begin
          h1 = 16'h7FFF;
          h2 = 16'h8000;
        end
        2: begin
          h1 = 16'h8000;
          h2 = 16'h7FFF;
        end
        default: begin
          h1 = 16'($urandom);
          h2 = 16'($urandom);
        end
      endcase
      program_regs(modes[p], h1, h2);
      idle_pct = idles[p];
      send_byte(8'($urandom_range(0, 255)), dafd_pkg::EMIT_NONE, 1'b1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_random_byte();
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pcm_pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0 && pcm_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
